FILE: design/cdm_pkg.sv
// Shared types, constants and format codes for the channel downmix block.
// No dependencies; every other file in this folder but cdm_stream_if uses it.
`timescale 1ns / 1ps

package cdm_pkg;

	localparam int WORD_W               = 32;
	localparam int NUM_WORDS            = 8;
	localparam int CNT_W                = 4;
	localparam int REM_W                = CNT_W - 1;
	localparam int DIV_STEP             = 7;
	localparam int DEFAULT_MAX_CHANNELS = 8;
	localparam int ADDR_W               = 3;
	localparam int DATA_W               = 32;

	typedef enum logic [1:0] {
		FMT_S16  = 2'd0,
		FMT_S24P = 2'd1,
		FMT_S24C = 2'd2,
		FMT_S32  = 2'd3
	} fmt_t;

	localparam logic REG_FMT = 1'b0;
	localparam logic REG_CNT = 1'b1;

	localparam fmt_t             FMT_RESET = FMT_S16;
	localparam logic [CNT_W-1:0] CNT_RESET = 4'd2;

	typedef struct packed {
		logic [WORD_W-1:0] sample_0;
		logic [WORD_W-1:0] sample_1;
		logic [WORD_W-1:0] sample_2;
		logic [WORD_W-1:0] sample_3;
		logic [WORD_W-1:0] sample_4;
		logic [WORD_W-1:0] sample_5;
		logic [WORD_W-1:0] sample_6;
		logic [WORD_W-1:0] sample_7;
		logic              last_frame;
	} frame_t;

	typedef struct packed {
		logic [WORD_W-1:0] mixed_sample;
		logic              last_frame_out;
	} mix_t;

endpackage

FILE: design/cdm_stream_if.sv
// Valid/ready stream channel carrying one payload of a chosen type.
// Depends on nothing; payload types come from cdm_pkg at the instance.
`timescale 1ns / 1ps

interface cdm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/channel_downmix_average.sv
// Top level of the channel downmix: config registers, lanes, merge tree,
// divider and output packing. Depends on cdm_pkg, cdm_stream_if, cdm_lane,
// cdm_adder_tree and cdm_divider.
//
// Usage: each request on the frame channel carries up to eight raw
// little-endian container words and a last-frame flag. The block decodes
// the first channel_count words per sample_format, sums them exactly,
// divides by the count (truncating toward zero) and packs the quotient back
// into the same container layout; one request leaves on the mix channel for
// each request taken. A count of one passes the word through, pad byte
// included; a count of zero yields zero.
// Pipeline: one lane register, the adder tree levels, an absolute-value
// stage, the divider stages at seven quotient bits each and the output
// register.
// Throughput: one request per cycle while mix.ready is high.
// Stall: a stage advances when it is empty or the one after it advances, so
// bubbles collapse and frame.ready stays high while mix.ready is high.
// Reset: arst_n clears all stage valid bits and loads sample_format = s16,
// channel_count = 2. Write the registers over APB only while idle.
`timescale 1ns / 1ps

module channel_downmix_average #(
	parameter int MAX_CHANNELS = cdm_pkg::DEFAULT_MAX_CHANNELS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	cdm_stream_if.sink                  frame,
	cdm_stream_if.source                mix,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cdm_pkg::ADDR_W-1:0]  paddr,
	input  logic [cdm_pkg::DATA_W-1:0]  pwdata,
	output logic [cdm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	localparam int LVL    = $clog2(MAX_CHANNELS);
	localparam int LANES  = 1 << LVL;
	localparam int SUM_W  = cdm_pkg::WORD_W + LVL;
	localparam int D      = (SUM_W + cdm_pkg::DIV_STEP - 1) / cdm_pkg::DIV_STEP;
	localparam int ABS_ST = LVL + 1;
	localparam int N      = LVL + 3 + D;

	typedef struct packed {
		cdm_pkg::fmt_t             fmt;
		logic [7:0]                pad;
		logic                      pass;
		logic [cdm_pkg::CNT_W-1:0] divisor;
		logic                      neg;
		logic                      last;
	} side_t;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	cdm_pkg::fmt_t             fmt_q;
	logic [cdm_pkg::CNT_W-1:0] cnt_q;
	logic                      reg_sel;

	// register index is the word address bit
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= cdm_pkg::FMT_RESET;
			cnt_q <= cdm_pkg::CNT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				cdm_pkg::REG_FMT: fmt_q <= cdm_pkg::fmt_t'(pwdata[1:0]);
				cdm_pkg::REG_CNT: cnt_q <= pwdata[cdm_pkg::CNT_W-1:0];
				default:          fmt_q <= fmt_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			cdm_pkg::REG_FMT: prdata = cdm_pkg::DATA_W'(fmt_q);
			cdm_pkg::REG_CNT: prdata = cdm_pkg::DATA_W'(cnt_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Stage flow control: advance a stage when it is empty or drains
	// ---------------------------------------------------------------
	logic [N-1:0] valid_s;
	logic [N-1:0] en;

	always_comb begin
		en[N-1] = !valid_s[N-1] || mix.ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !valid_s[k] || en[k+1];
		end
	end

	assign frame.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[0]) begin
				valid_s[0] <= frame.valid;
			end
			for (int k = 1; k < N; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Request side info: saturate the count, hold the pad byte
	// ---------------------------------------------------------------
	logic [cdm_pkg::CNT_W-1:0] sat_cnt;
	side_t                     side_in;
	side_t                     side_s [N];
	side_t                     side_abs;
	logic signed [SUM_W-1:0]   total;
	logic                      total_neg;

	assign sat_cnt = (cnt_q > cdm_pkg::CNT_W'(MAX_CHANNELS)) ?
	                 cdm_pkg::CNT_W'(MAX_CHANNELS) : cnt_q;

	always_comb begin
		side_in.fmt     = fmt_q;
		side_in.pad     = frame.data.sample_0[31:24];
		side_in.pass    = (sat_cnt == cdm_pkg::CNT_W'(1));
		// zero channels sum to zero; divide that by one
		side_in.divisor = (sat_cnt == '0) ? cdm_pkg::CNT_W'(1) : sat_cnt;
		side_in.neg     = 1'b0;
		side_in.last    = frame.data.last_frame;
	end

	assign total_neg = total < 0;

	// record the sign of the sum as it enters the absolute-value stage
	always_comb begin
		side_abs     = side_s[ABS_ST-1];
		side_abs.neg = total_neg;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s[0] <= side_in;
		end
		for (int k = 1; k < N; k++) begin
			if (en[k]) begin
				side_s[k] <= (k == ABS_ST) ? side_abs : side_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Decode lanes and merge tree
	// ---------------------------------------------------------------
	logic [cdm_pkg::WORD_W-1:0]        words [cdm_pkg::NUM_WORDS];
	logic signed [cdm_pkg::WORD_W-1:0] lane_val [LANES];

	assign words[0] = frame.data.sample_0;
	assign words[1] = frame.data.sample_1;
	assign words[2] = frame.data.sample_2;
	assign words[3] = frame.data.sample_3;
	assign words[4] = frame.data.sample_4;
	assign words[5] = frame.data.sample_5;
	assign words[6] = frame.data.sample_6;
	assign words[7] = frame.data.sample_7;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		cdm_lane u_lane (
			.word   (words[i]),
			.fmt    (fmt_q),
			.enable (cdm_pkg::CNT_W'(i) < sat_cnt),
			.value  (lane_val[i])
		);
	end

	cdm_adder_tree #(
		.LANES (LANES),
		.LVL   (LVL),
		.SUM_W (SUM_W)
	) u_tree (
		.clk   (clk),
		.en    (en[LVL:0]),
		.leaf  (lane_val),
		.total (total)
	);

	// ---------------------------------------------------------------
	// Absolute value, then divide the magnitude
	// ---------------------------------------------------------------
	logic [SUM_W-1:0]           mag_s;
	logic [cdm_pkg::WORD_W-1:0] quot;

	always_ff @(posedge clk) begin
		if (en[ABS_ST]) begin
			mag_s <= total_neg ? SUM_W'(-total) : SUM_W'(total);
		end
	end

	cdm_divider #(
		.MAG_W  (SUM_W),
		.STAGES (D)
	) u_div (
		.clk     (clk),
		.en      (en[ABS_ST+D:ABS_ST+1]),
		.mag     (mag_s),
		.divisor (side_s[ABS_ST].divisor),
		.quot    (quot)
	);

	// ---------------------------------------------------------------
	// Restore sign and pack into the container; hold until taken
	// ---------------------------------------------------------------
	side_t                      side_d;
	logic [cdm_pkg::WORD_W-1:0] signed_q;
	logic [cdm_pkg::WORD_W-1:0] packed_w;
	cdm_pkg::mix_t              mix_s;

	assign side_d   = side_s[N-2];
	assign signed_q = side_d.neg ? (~quot + cdm_pkg::WORD_W'(1)) : quot;

	always_comb begin
		unique case (side_d.fmt)
			cdm_pkg::FMT_S16:  packed_w = {16'h0000, signed_q[15:0]};
			cdm_pkg::FMT_S24P: packed_w = {8'h00, signed_q[23:0]};
			// single channel keeps the pad byte as it arrived
			cdm_pkg::FMT_S24C: packed_w = {side_d.pass ? side_d.pad : 8'h00, signed_q[23:0]};
			cdm_pkg::FMT_S32:  packed_w = signed_q;
			default:           packed_w = signed_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[N-1]) begin
			mix_s.mixed_sample   <= packed_w;
			mix_s.last_frame_out <= side_d.last;
		end
	end

	assign mix.valid = valid_s[N-1];
	assign mix.data  = mix_s;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_no_input_stall : assert property (@(posedge clk) disable iff (!arst_n)
		mix.ready |-> frame.ready)
		else $error("input stalled while output drains");

	a_s16_high_zero : assert property (@(posedge clk) disable iff (!arst_n)
		mix.valid && side_s[N-1].fmt == cdm_pkg::FMT_S16
		|-> mix.data.mixed_sample[31:16] == 16'h0000)
		else $error("s16 result has nonzero high half");

	a_s24p_top_zero : assert property (@(posedge clk) disable iff (!arst_n)
		mix.valid && side_s[N-1].fmt == cdm_pkg::FMT_S24P
		|-> mix.data.mixed_sample[31:24] == 8'h00)
		else $error("packed s24 result has nonzero top byte");

	a_s24c_pad : assert property (@(posedge clk) disable iff (!arst_n)
		mix.valid && side_s[N-1].fmt == cdm_pkg::FMT_S24C && !side_s[N-1].pass
		|-> mix.data.mixed_sample[31:24] == 8'h00)
		else $error("averaged s24 container has nonzero pad byte");

endmodule

FILE: design/cdm_lane.sv
// One decode lane: sign-extends a raw container word per the sample format.
// Depends on cdm_pkg.
`timescale 1ns / 1ps

module cdm_lane (
	input  logic [cdm_pkg::WORD_W-1:0]        word,
	input  cdm_pkg::fmt_t                     fmt,
	input  logic                              enable,
	output logic signed [cdm_pkg::WORD_W-1:0] value
);

	logic signed [cdm_pkg::WORD_W-1:0] decoded;

	always_comb begin
		unique case (fmt)
			cdm_pkg::FMT_S16:  decoded = {{16{word[15]}}, word[15:0]};
			cdm_pkg::FMT_S24P: decoded = {{8{word[23]}}, word[23:0]};
			cdm_pkg::FMT_S24C: decoded = {{8{word[23]}}, word[23:0]};
			cdm_pkg::FMT_S32:  decoded = word;
			default:           decoded = word;
		endcase
	end

	// drop channels beyond the configured count
	assign value = enable ? decoded : '0;

endmodule

FILE: design/cdm_adder_tree.sv
// Registered merge tree: captures lane values, then sums pairs level by level.
// Depends on cdm_pkg.
`timescale 1ns / 1ps

module cdm_adder_tree #(
	parameter int LANES = 8,
	parameter int LVL   = 3,
	parameter int SUM_W = 35
) (
	input  logic                              clk,
	input  logic [LVL:0]                      en,
	input  logic signed [cdm_pkg::WORD_W-1:0] leaf [LANES],
	output logic signed [SUM_W-1:0]           total
);

	logic signed [SUM_W-1:0] node_q [LVL+1][LANES];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < LANES; i++) begin
				node_q[0][i] <= SUM_W'(leaf[i]);
			end
		end
		for (int l = 1; l <= LVL; l++) begin
			if (en[l]) begin
				for (int i = 0; i < (LANES >> l); i++) begin
					node_q[l][i] <= node_q[l-1][2*i] + node_q[l-1][2*i+1];
				end
			end
		end
	end

	assign total = node_q[LVL][0];

endmodule

FILE: design/cdm_divider.sv
// Pipelined restoring divider of a magnitude by a small channel count,
// a fixed number of quotient bits per stage. Depends on cdm_pkg.
`timescale 1ns / 1ps

module cdm_divider #(
	parameter int MAG_W  = 35,
	parameter int STAGES = 5
) (
	input  logic                       clk,
	input  logic [STAGES-1:0]          en,
	input  logic [MAG_W-1:0]           mag,
	input  logic [cdm_pkg::CNT_W-1:0]  divisor,
	output logic [cdm_pkg::WORD_W-1:0] quot
);

	localparam int PAD_W = STAGES * cdm_pkg::DIV_STEP;

	logic [PAD_W-1:0]          w_q   [STAGES];
	logic [cdm_pkg::REM_W-1:0] rem_q [STAGES];
	logic [cdm_pkg::CNT_W-1:0] div_q [STAGES];

	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		logic [PAD_W-1:0]          w_in;
		logic [cdm_pkg::REM_W-1:0] r_in;
		logic [cdm_pkg::CNT_W-1:0] d_in;
		logic [PAD_W-1:0]          w_nx;
		logic [cdm_pkg::REM_W-1:0] r_nx;

		if (j == 0) begin : g_first
			assign w_in = PAD_W'(mag);
			assign r_in = '0;
			assign d_in = divisor;
		end else begin : g_next
			assign w_in = w_q[j-1];
			assign r_in = rem_q[j-1];
			assign d_in = div_q[j-1];
		end

		always_comb begin
			logic [cdm_pkg::CNT_W-1:0] t;
			w_nx = w_in;
			r_nx = r_in;
			for (int k = 0; k < cdm_pkg::DIV_STEP; k++) begin
				t    = {r_nx, w_nx[PAD_W-1]};
				w_nx = w_nx << 1;
				if (t >= d_in) begin
					t       = t - d_in;
					w_nx[0] = 1'b1;
				end
				r_nx = t[cdm_pkg::REM_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				w_q[j]   <= w_nx;
				rem_q[j] <= r_nx;
				div_q[j] <= d_in;
			end
		end
	end

	assign quot = w_q[STAGES-1][cdm_pkg::WORD_W-1:0];

endmodule
